>>> hdl/bxr_pkg.sv
// Shared types, codes and rotate function for the bounded random unit
package bxr_pkg;

    localparam int WordWidth = 64;
    localparam int FracWidth = 53;
    localparam int ProbWidth = 54;
    localparam int LenWidth  = 32;
    localparam int SeedCount = 4;
    localparam int QueueDepthDefault = 2;

    localparam logic [1:0] OP_INT    = 2'd0;
    localparam logic [1:0] OP_FRAC   = 2'd1;
    localparam logic [1:0] OP_CHANCE = 2'd2;
    localparam logic [1:0] OP_CHOICE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_UNDEF   = 2'd2;

    // Work kinds handed from the front to the back
    localparam logic [2:0] JOB_DONE     = 3'd0;  // result fully known at the front
    localparam logic [2:0] JOB_BOUNDED  = 3'd1;  // rejection draw modulo span
    localparam logic [2:0] JOB_RAW      = 3'd2;  // one raw word (full span)
    localparam logic [2:0] JOB_FRAC     = 3'd3;
    localparam logic [2:0] JOB_CHANCE   = 3'd4;

    typedef struct packed {
        logic [1:0]           operation;
        logic signed [63:0]   range_min;
        logic signed [63:0]   range_max;
        logic [ProbWidth-1:0] probability;
        logic [LenWidth-1:0]  list_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic signed [63:0]   int_value;
        logic [FracWidth-1:0] fraction_value;
        logic                 chance_result;
        logic [LenWidth-1:0]  chosen_index;
        logic                 nothing_chosen;
    } out_item_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic                 is_choice;
        logic [WordWidth-1:0] span;   // bound (span or list length) or probability
        logic [WordWidth-1:0] base;
        out_item_t            early;  // result for JOB_DONE
    } job_t;

    typedef logic [WordWidth-1:0] gen_state_t [SeedCount];

    function automatic logic [WordWidth-1:0] rotl(input logic [WordWidth-1:0] v,
                                                   input int k);
        rotl = (v << k) | (v >> (WordWidth - k));
    endfunction

endpackage

>>> hdl/bounded_xoshiro_random_unit_top.sv
// Results known from the arguments skip the generator; fraction, chance and full-span
// draws use one generator word; bounded draws reject low words, then reduce modulo span.
// Throughput: one item at a time in the back end, set by the 64-step serial remainder
// unit run twice per bounded draw; a two-entry queue decouples the front.
// Reset: asynchronous active low; clears seeds, generator words, seeded flag and queue.
// Top level of the bounded random unit
module bounded_xoshiro_random_unit_top #(
    parameter int QueueDepth = bxr_pkg::QueueDepthDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bxr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bxr_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import bxr_pkg::*;

    gen_state_t seed_reg;
    logic       seeded_reg;
    logic       seed_load;
    logic       job_valid;
    logic       job_pop;
    job_t       job_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
            for (int i = 0; i < SeedCount; i++)
                seed_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                seed_reg[cfg_index] <= cfg_data;
            if (seed_load)
                seeded_reg <= 1'b1;
        end
    end

    bxr_front #(.QueueDepth(QueueDepth)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .seed_or   (seed_reg[0] | seed_reg[1] | seed_reg[2] | seed_reg[3]),
        .seeded    (seeded_reg),
        .seed_load (seed_load),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job_data  (job_data)
    );

    bxr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_pop    (job_pop),
        .job_data   (job_data),
        .seed_load  (seed_load),
        .seed_words (seed_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

>>> hdl/bxr_front.sv
// Front end: accepts requests, checks arguments, seeds the generator, queues jobs
module bxr_front #(
    parameter int QueueDepth = bxr_pkg::QueueDepthDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bxr_pkg::in_item_t   in_data,
    input  logic [63:0]         seed_or,
    input  logic                seeded,
    output logic                seed_load,
    output logic                job_valid,
    input  logic                job_pop,
    output bxr_pkg::job_t       job_data
);
    import bxr_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    job_t             queue_reg [QueueDepth];
    logic [PtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]  count_reg;
    logic             push;
    logic             pop;
    job_t             job;
    logic [63:0]      lo, hi;
    logic             seed_ok;
    logic             needs_gen;

    assign in_stall  = (count_reg == CntW'(QueueDepth));
    assign push      = in_valid && !in_stall;
    assign pop       = job_pop && (count_reg != '0);
    assign job_valid = (count_reg != '0);
    assign job_data  = queue_reg[rd_ptr_reg];

    assign lo      = in_data.range_min ^ {1'b1, 63'd0};
    assign hi      = in_data.range_max ^ {1'b1, 63'd0};
    assign seed_ok = seeded || (seed_or != '0);

    always_comb
    begin
        job       = '0;
        needs_gen = 1'b0;
        unique case (in_data.operation)
            OP_INT:
            begin
                if (lo > hi)
                    job.early.status = ST_INVALID;
                else
                begin
                    needs_gen = 1'b1;
                    job.span  = hi - lo + 64'd1;
                    job.base  = lo;
                    job.kind  = (job.span == '0) ? JOB_RAW : JOB_BOUNDED;
                end
            end
            OP_FRAC:
            begin
                needs_gen = 1'b1;
                job.kind  = JOB_FRAC;
            end
            OP_CHANCE:
            begin
                if (in_data.probability > {1'b1, 53'd0})
                    job.early.status = ST_INVALID;
                else
                begin
                    needs_gen = 1'b1;
                    job.span  = {10'd0, in_data.probability};
                    if (in_data.probability == {1'b1, 53'd0})
                        job.early.chance_result = 1'b1;
                    else if (in_data.probability != '0)
                        job.kind = JOB_CHANCE;
                end
            end
            default:
            begin
                if (in_data.list_length == '0)
                    job.early.nothing_chosen = 1'b1;
                else
                begin
                    needs_gen     = 1'b1;
                    job.is_choice = 1'b1;
                    job.span      = {32'd0, in_data.list_length};
                    job.kind      = JOB_BOUNDED;
                end
            end
        endcase
        if (needs_gen && !seed_ok)
        begin
            job      = '0;
            job.early.status = ST_UNDEF;
        end
    end

    assign seed_load = push && needs_gen && !seeded && (seed_or != '0);

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CntW'(push) - CntW'(pop);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(QueueDepth))
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CntW'(QueueDepth)) |-> !push)
        else $error("push into full queue");
    a_seed_once: assert property (@(posedge clk) disable iff (!rst_n)
        seed_load |-> !seeded)
        else $error("seed load while seeded");

endmodule

>>> hdl/bxr_divider.sv
// Serial restoring 64-bit remainder unit, one quotient bit per cycle while busy
module bxr_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] remainder
);
    import bxr_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] num_reg;
    logic [63:0] div_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [64:0] trial;

    assign trial     = {rem_reg, num_reg[63]};
    assign rem_next  = (trial >= {1'b0, div_reg}) ? 64'(trial - {1'b0, div_reg})
                                                  : trial[63:0];
    assign remainder = rem_reg;
    assign done      = busy_reg && (cnt_reg == 7'd0);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != 7'd0)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[62:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 7'd64;
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
            cnt_reg <= cnt_reg - 7'd1;
    end

endmodule

>>> hdl/bxr_back.sv
// Back end: generator, rejection sampling, modulo reduction and result register
module bxr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_pop,
    input  bxr_pkg::job_t       job_data,
    input  logic                seed_load,
    input  bxr_pkg::gen_state_t seed_words,
    output logic                out_valid,
    input  logic                out_stall,
    output bxr_pkg::out_item_t  out_data
);
    import bxr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CUT  = 3'd1;  // compute (2^64 - span) mod span
    localparam logic [2:0] S_DRAW = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]   state_reg;
    gen_state_t   gen_reg, gen_next;
    logic [63:0]  word;
    job_t         job_reg;
    logic [63:0]  cut_reg;
    logic         div_start;
    logic [63:0]  div_dividend;
    logic         div_done;
    logic [63:0]  div_rem;
    logic [63:0]  mul_reg;
    logic         mul_phase_reg;
    out_item_t    res_reg;
    logic         advance;

    bxr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (job_reg.span),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Output word from the registered multiply; second multiply after a register
    assign word = rotl(mul_reg, 7) * 64'd9;

    always_comb
    begin
        gen_next    = gen_reg;
        gen_next[2] = gen_reg[2] ^ gen_reg[0];
        gen_next[3] = gen_reg[3] ^ gen_reg[1];
        gen_next[1] = gen_reg[1] ^ gen_next[2];
        gen_next[0] = gen_reg[0] ^ gen_next[3];
        gen_next[2] = gen_next[2] ^ (gen_reg[1] << 17);
        gen_next[3] = rotl(gen_next[3], 45);
    end

    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = word;
        if (state_reg == S_IDLE && job_valid && job_data.kind == JOB_BOUNDED)
            div_start = 1'b0;
        if (state_reg == S_CUT && !mul_phase_reg)
        begin
            div_start    = 1'b1;
            div_dividend = 64'd0 - job_reg.span;
        end
        advance = (state_reg == S_DRAW) && mul_phase_reg;
        if (advance && job_reg.kind == JOB_BOUNDED && word >= cut_reg)
            div_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_phase_reg <= 1'b0;
            for (int i = 0; i < SeedCount; i++)
                gen_reg[i] <= '0;
        end
        else
        begin
            if (seed_load)
                gen_reg <= seed_words;
            unique case (state_reg)
                S_IDLE:
                begin
                    mul_phase_reg <= 1'b0;
                    if (job_valid)
                    begin
                        job_reg <= job_data;
                        res_reg <= job_data.early;
                        if (job_data.kind == JOB_DONE)
                            state_reg <= S_OUT;
                        else if (job_data.kind == JOB_BOUNDED)
                            state_reg <= S_CUT;
                        else
                            state_reg <= S_DRAW;
                    end
                end
                S_CUT:
                begin
                    mul_phase_reg <= 1'b1;
                    if (div_done)
                    begin
                        cut_reg       <= div_rem;
                        mul_phase_reg <= 1'b0;
                        state_reg     <= S_DRAW;
                    end
                end
                S_DRAW:
                begin
                    if (!mul_phase_reg)
                    begin
                        mul_reg       <= gen_reg[1] * 64'd5;
                        mul_phase_reg <= 1'b1;
                    end
                    else
                    begin
                        gen_reg       <= gen_next;
                        mul_phase_reg <= 1'b0;
                        case (job_reg.kind)
                            JOB_RAW:
                            begin
                                res_reg.int_value <= word + job_reg.base ^ {1'b1, 63'd0};
                                state_reg <= S_OUT;
                            end
                            JOB_FRAC:
                            begin
                                res_reg.fraction_value <= word[63:11];
                                state_reg <= S_OUT;
                            end
                            JOB_CHANCE:
                            begin
                                res_reg.chance_result <=
                                    ({11'd0, word[63:11]} < job_reg.span);
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                if (word >= cut_reg)
                                    state_reg <= S_MOD;
                            end
                        endcase
                    end
                end
                S_MOD:
                begin
                    if (div_done)
                    begin
                        if (job_reg.is_choice)
                            res_reg.chosen_index <= div_rem[31:0];
                        else
                            res_reg.int_value <=
                                (div_rem + job_reg.base) ^ {1'b1, 63'd0};
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (state_reg != S_IDLE))
        else $error("job taken without leaving idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(res_reg)))
        else $error("result changed while stalled");
    a_mod_needs_cut: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (job_reg.kind == JOB_BOUNDED))
        else $error("modulo for non bounded job");

endmodule

>>> sim/bounded_xoshiro_random_unit_top_tb.sv
// Self-checking testbench for the bounded random unit: random and directed requests
`timescale 1ns / 1ps

module bounded_xoshiro_random_unit_top_tb;
    import bxr_pkg::*;

    localparam logic [1:0] REG_SEED0 = 2'd0;
    localparam logic [1:0] REG_SEED1 = 2'd1;
    localparam logic [1:0] REG_SEED2 = 2'd2;
    localparam logic [1:0] REG_SEED3 = 2'd3;
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [ProbWidth-1:0] PROB_ONE = 54'h20_0000_0000_0000;
    localparam int RANDOM_ITEMS = 530;
    localparam int IDLE_LIMIT = 20000;

    class draw_scoreboard;
        logic [63:0] seed_reg [SeedCount];
        logic [63:0] gen [SeedCount];
        bit          seeded;
        out_item_t   expected_q [$];
        int          errors;

        function new();
            foreach (seed_reg[i]) seed_reg[i] = '0;
            foreach (gen[i]) gen[i] = '0;
            seeded = 0;
            errors = 0;
        endfunction

        function void write_seed(logic [1:0] idx, logic [63:0] val);
            seed_reg[idx] = val;
        endfunction

        function logic [63:0] rot(logic [63:0] v, int k);
            return (v << k) | (v >> (64 - k));
        endfunction

        function logic [63:0] advance();
            logic [63:0] word;
            logic [63:0] t;
            word = rot(gen[1] * 64'd5, 7) * 64'd9;
            t = gen[1] << 17;
            gen[2] ^= gen[0];
            gen[3] ^= gen[1];
            gen[1] ^= gen[2];
            gen[0] ^= gen[3];
            gen[2] ^= t;
            gen[3] = rot(gen[3], 45);
            return word;
        endfunction

        function bit load_seed();
            if (seeded)
                return 1;
            if ((seed_reg[0] | seed_reg[1] | seed_reg[2] | seed_reg[3]) == 0)
                return 0;
            foreach (gen[i]) gen[i] = seed_reg[i];
            seeded = 1;
            return 1;
        endfunction

        // span of zero stands for the full 2^64 range
        function logic [63:0] uniform_below(logic [63:0] span);
            logic [63:0] cut;
            logic [63:0] w;
            if (span == 0)
                return advance();
            cut = (64'd0 - span) % span;
            do
                w = advance();
            while (w < cut);
            return w % span;
        endfunction

        function void note_input(in_item_t it);
            out_item_t r;
            logic [63:0] lo;
            logic [63:0] hi;
            r = '0;
            lo = it.range_min ^ SIGN_BIT;
            hi = it.range_max ^ SIGN_BIT;
            case (it.operation)
                OP_INT:
                    if (lo > hi)
                        r.status = ST_INVALID;
                    else if (!load_seed())
                        r.status = ST_UNDEF;
                    else
                        r.int_value = (lo + uniform_below(hi - lo + 64'd1)) ^ SIGN_BIT;
                OP_FRAC:
                    if (!load_seed())
                        r.status = ST_UNDEF;
                    else
                        r.fraction_value = FracWidth'(advance() >> 11);
                OP_CHANCE:
                    if (it.probability > PROB_ONE)
                        r.status = ST_INVALID;
                    else if (!load_seed())
                        r.status = ST_UNDEF;
                    else if (it.probability == PROB_ONE)
                        r.chance_result = 1'b1;
                    else if (it.probability != 0)
                        r.chance_result = (advance() >> 11) < 64'(it.probability);
                default:
                    if (it.list_length == 0)
                        r.nothing_chosen = 1'b1;
                    else if (!load_seed())
                        r.status = ST_UNDEF;
                    else
                        r.chosen_index = LenWidth'(uniform_below(64'(it.list_length)));
            endcase
            expected_q.push_back(r);
        endfunction

        function void report(string field, logic [63:0] e, logic [63:0] a);
            errors++;
            $display("%0t: %s expected %h actual %h", $time, field, e, a);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status)
                report("status", 64'(e.status), 64'(got.status));
            if (got.int_value !== e.int_value)
                report("int_value", e.int_value, got.int_value);
            if (got.fraction_value !== e.fraction_value)
                report("fraction_value", 64'(e.fraction_value), 64'(got.fraction_value));
            if (got.chance_result !== e.chance_result)
                report("chance_result", 64'(e.chance_result), 64'(got.chance_result));
            if (got.chosen_index !== e.chosen_index)
                report("chosen_index", 64'(e.chosen_index), 64'(got.chosen_index));
            if (got.nothing_chosen !== e.nothing_chosen)
                report("nothing_chosen", 64'(e.nothing_chosen), 64'(got.nothing_chosen));
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    draw_scoreboard sb;
    int idle_cycles;
    int stall_mode;
    int stall_left;

    bounded_xoshiro_random_unit_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver: switch stall style every so often
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode = $urandom_range(0, 2);
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 9) < 3);
        else if (stall_mode == 2 && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 20);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("bounded_xoshiro_random_unit_top_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_item_t make_req(logic [1:0] op, logic [63:0] lo, logic [63:0] hi,
                                          logic [ProbWidth-1:0] p, logic [31:0] len);
        in_item_t it;
        it.operation   = op;
        it.range_min   = lo;
        it.range_max   = hi;
        it.probability = p;
        it.list_length = len;
        return it;
    endfunction

    function automatic in_item_t random_req();
        in_item_t it;
        logic signed [63:0] a;
        logic signed [63:0] b;
        it = make_req(2'($urandom_range(0, 3)), rand64(), rand64(),
                      ProbWidth'(rand64()), $urandom);
        case (it.operation)
            OP_INT:
                case ($urandom_range(0, 7))
                    0: begin it.range_min = SIGN_BIT; it.range_max = ~SIGN_BIT; end
                    1: it.range_max = it.range_min;
                    2, 3:
                    begin
                        a = $signed(rand64()) >>> 1;
                        it.range_min = a;
                        it.range_max = a + $urandom_range(0, 1000);
                    end
                    4: it.range_min = SIGN_BIT;
                    5: ;
                    default:
                    begin
                        a = rand64();
                        b = rand64();
                        it.range_min = (a < b) ? a : b;
                        it.range_max = (a < b) ? b : a;
                    end
                endcase
            OP_CHANCE:
                case ($urandom_range(0, 5))
                    0: it.probability = '0;
                    1: it.probability = PROB_ONE;
                    2: ;
                    default: it.probability = it.probability & (PROB_ONE - 1);
                endcase
            OP_CHOICE:
                case ($urandom_range(0, 5))
                    0: it.list_length = '0;
                    1: it.list_length = $urandom_range(1, 2);
                    2, 3: it.list_length = $urandom_range(1, 1000);
                    default: ;
                endcase
            default: ;
        endcase
        return it;
    endfunction

    task automatic send(in_item_t it);
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = it;
        while (1)
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        sb.note_input(it);
    endtask

    // bursts of transfers with random gaps in between
    task automatic send_list(in_item_t items [$]);
        int burst;
        burst = 0;
        foreach (items[i])
        begin
            if (burst == 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
                burst = $urandom_range(1, 10);
            end
            burst--;
            send(items[i]);
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_seed(idx, val);
    endtask

    function automatic void add_edges(ref in_item_t q [$]);
        q.push_back(make_req(OP_INT, SIGN_BIT, ~SIGN_BIT, '0, '0));
        q.push_back(make_req(OP_INT, ~SIGN_BIT, SIGN_BIT, '1, '1));
        q.push_back(make_req(OP_INT, ~SIGN_BIT, ~SIGN_BIT, '0, '0));
        q.push_back(make_req(OP_INT, SIGN_BIT, SIGN_BIT, '0, '0));
        q.push_back(make_req(OP_INT, -64'sd3, 64'sd3, '0, '0));
        q.push_back(make_req(OP_FRAC, '1, '0, '1, '1));
        q.push_back(make_req(OP_CHANCE, '0, '0, '0, '0));
        q.push_back(make_req(OP_CHANCE, '0, '0, PROB_ONE, '0));
        q.push_back(make_req(OP_CHANCE, '0, '0, PROB_ONE + 1, '0));
        q.push_back(make_req(OP_CHANCE, '0, '0, '1, '0));
        q.push_back(make_req(OP_CHANCE, '0, '0, PROB_ONE - 1, '0));
        q.push_back(make_req(OP_CHOICE, '0, '0, '0, '0));
        q.push_back(make_req(OP_CHOICE, '0, '0, '0, 32'd1));
        q.push_back(make_req(OP_CHOICE, '0, '0, '0, '1));
    endfunction

    initial
    begin
        in_item_t items [$];
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SEED0;
        cfg_data = '0;
        stall_mode = 0;
        stall_left = 0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero seed: every draw must come back undefined
        add_edges(items);
        send_list(items);
        drain();

        write_reg(REG_SEED0, '1);
        write_reg(REG_SEED1, '1);
        write_reg(REG_SEED2, '0);
        write_reg(REG_SEED3, rand64());
        items = {};
        add_edges(items);
        send_list(items);
        drain();

        // generator already loaded; these writes must not disturb it
        write_reg(REG_SEED0, '0);
        write_reg(REG_SEED1, rand64());
        write_reg(REG_SEED2, '1);
        write_reg(REG_SEED3, '0);
        items = {};
        repeat (RANDOM_ITEMS) items.push_back(random_req());
        send_list(items);
        drain();
        repeat (200) @(posedge clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("bounded_xoshiro_random_unit_top_tb OK");
        else
            $display("bounded_xoshiro_random_unit_top_tb NOT OK");
        $finish;
    end

endmodule

>>> bounded_xoshiro_random_unit_top.f
hdl/bxr_pkg.sv
hdl/bxr_front.sv
hdl/bxr_divider.sv
hdl/bxr_back.sv
hdl/bounded_xoshiro_random_unit_top.sv
sim/bounded_xoshiro_random_unit_top_tb.sv
